>>> src/gac_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gac_pkg - shared types and constants for the generator autostart controller
// Configuration layout, register indexes, key codes and status word fields.
// ----------------------------------------------------------------------------
package gac_pkg;

    localparam int MAX_ATTEMPTS_DEF = 3;

    localparam int ADC_W   = 10;
    localparam int KEY_W   = 3;
    localparam int MV_W    = 15;
    localparam int THR_W   = 14;
    localparam int REST_W  = 10;
    localparam int CRANK_W = 5;
    localparam int IDLE_W  = 7;
    localparam int ATT_W   = 2;
    localparam int IDX_W   = 3;
    localparam int DATA_W  = 15;
    localparam int PROD_W  = ADC_W + MV_W;

    // floor(p / 1023) == (p * RECIP_1023) >> RECIP_SHIFT for p < 2**25
    localparam int RECIP_SHIFT = 35;
    localparam int RECIP_W     = 26;
    localparam logic [RECIP_W-1:0] RECIP_1023 = 26'd33587233;

    localparam logic [MV_W-1:0] HYST_MV     = 15'd200;
    localparam logic [MV_W-1:0] FAILSAFE_MV = 15'd14000;

    localparam logic [KEY_W-1:0] KEY_UP     = 3'd1;
    localparam logic [KEY_W-1:0] KEY_DOWN   = 3'd2;
    localparam logic [KEY_W-1:0] KEY_SELECT = 3'd4;
    localparam logic [KEY_W-1:0] KEY_NONE   = 3'd5;

    localparam logic [IDX_W-1:0] REG_MIN_THR   = 3'd0;
    localparam logic [IDX_W-1:0] REG_MAX_THR   = 3'd1;
    localparam logic [IDX_W-1:0] REG_REST      = 3'd2;
    localparam logic [IDX_W-1:0] REG_CRANK     = 3'd3;
    localparam logic [IDX_W-1:0] REG_FULLSCALE = 3'd4;
    localparam logic [IDX_W-1:0] REG_IDLE      = 3'd5;

    localparam logic [THR_W-1:0]   MIN_THR_RST   = 14'd11500;
    localparam logic [THR_W-1:0]   MAX_THR_RST   = 14'd13500;
    localparam logic [REST_W-1:0]  REST_RST      = 10'd300;
    localparam logic [CRANK_W-1:0] CRANK_RST     = 5'd25;
    localparam logic [MV_W-1:0]    FULLSCALE_RST = 15'd31000;
    localparam logic [IDLE_W-1:0]  IDLE_RST      = 7'd100;

    typedef struct packed {
        logic [THR_W-1:0]   min_threshold_mv;
        logic [THR_W-1:0]   max_threshold_mv;
        logic [REST_W-1:0]  rest_ticks;
        logic [CRANK_W-1:0] crank_ticks;
        logic [MV_W-1:0]    full_scale_mv;
        logic [IDLE_W-1:0]  idle_limit;
    } cfg_t;

    typedef struct packed {
        logic            coil_on;
        logic            starter_on;
        logic            start_failed;
        logic            automation_on;
        logic            screen_on;
        logic [MV_W-1:0] battery_mv;
    } status_t;

endpackage
`default_nettype wire

>>> src/gac_scale.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gac_scale - battery sample scaling pipeline
// Input register, sample times full scale, then exact divide by 1023 via a
// reciprocal multiply. Key and running sense travel alongside.
// ----------------------------------------------------------------------------
module gac_scale
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        up_valid,
    output logic                             up_ready,
    input  wire logic [gac_pkg::ADC_W-1:0]   up_adc,
    input  wire logic                        up_gen,
    input  wire logic [gac_pkg::KEY_W-1:0]   up_key,
    input  wire logic [gac_pkg::MV_W-1:0]    full_scale_mv,
    output logic                             dn_valid,
    input  wire logic                        dn_ready,
    output logic [gac_pkg::MV_W-1:0]         dn_mv,
    output logic                             dn_gen,
    output logic [gac_pkg::KEY_W-1:0]        dn_key
);

    localparam int RP_W = gac_pkg::PROD_W + gac_pkg::RECIP_W;

    logic                          v0_reg, v1_reg, v2_reg;
    logic                          rdy0, rdy1, rdy2;
    logic [gac_pkg::ADC_W-1:0]     adc0_reg;
    logic                          gen0_reg, gen1_reg, gen2_reg;
    logic [gac_pkg::KEY_W-1:0]     key0_reg, key1_reg, key2_reg;
    logic [gac_pkg::PROD_W-1:0]    prod_reg, prod_next;
    logic [gac_pkg::MV_W-1:0]      mv_reg, mv_next;
    logic [RP_W-1:0]               recip_prod;

    assign rdy2     = !v2_reg || dn_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign rdy0     = !v0_reg || rdy1;
    assign up_ready = rdy0;

    assign prod_next  = {{gac_pkg::MV_W{1'b0}}, adc0_reg}
                      * {{gac_pkg::ADC_W{1'b0}}, full_scale_mv};
    assign recip_prod = {{gac_pkg::RECIP_W{1'b0}}, prod_reg}
                      * {{gac_pkg::PROD_W{1'b0}}, gac_pkg::RECIP_1023};
    assign mv_next    = recip_prod[gac_pkg::RECIP_SHIFT +: gac_pkg::MV_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy0)
            begin
                v0_reg <= up_valid;
            end
            if (rdy1)
            begin
                v1_reg <= v0_reg;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy0 && up_valid)
        begin
            adc0_reg <= up_adc;
            gen0_reg <= up_gen;
            key0_reg <= up_key;
        end
        if (rdy1 && v0_reg)
        begin
            prod_reg <= prod_next;
            gen1_reg <= gen0_reg;
            key1_reg <= key0_reg;
        end
        if (rdy2 && v1_reg)
        begin
            mv_reg   <= mv_next;
            gen2_reg <= gen1_reg;
            key2_reg <= key1_reg;
        end
    end

    assign dn_valid = v2_reg;
    assign dn_mv    = mv_reg;
    assign dn_gen   = gen2_reg;
    assign dn_key   = key2_reg;

endmodule
`default_nettype wire

>>> src/gac_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gac_ctrl - per-tick controller state and result register
// Idle timer, held-key suppression, automation toggle, crank/rest sequencing
// with retry and failure latch, hysteresis and stop conditions.
// ----------------------------------------------------------------------------
module gac_ctrl
#(
    parameter int MAX_ATTEMPTS = gac_pkg::MAX_ATTEMPTS_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire gac_pkg::cfg_t              cfg,
    input  wire logic                       up_valid,
    output logic                            up_ready,
    input  wire logic [gac_pkg::MV_W-1:0]   up_mv,
    input  wire logic                       up_gen,
    input  wire logic [gac_pkg::KEY_W-1:0]  up_key,
    output logic                            dn_valid,
    input  wire logic                       dn_ready,
    output gac_pkg::status_t                dn_status
);

    localparam logic [gac_pkg::ATT_W:0] MAX_ATT = (gac_pkg::ATT_W+1)'(MAX_ATTEMPTS);

    logic                            out_valid_reg;
    gac_pkg::status_t                status_reg, status_next;
    logic                            step;

    logic                            auto_reg, auto_next;
    logic                            disp_reg, disp_next;
    logic [gac_pkg::IDLE_W-1:0]      idle_reg, idle_next, idle_inc;
    logic                            prev_reg, prev_next;
    logic                            coil_reg, coil_next;
    logic                            starter_reg, starter_next;
    logic                            thr_reg, thr_next;
    logic [gac_pkg::CRANK_W-1:0]     crank_reg, crank_next;
    logic [gac_pkg::REST_W-1:0]      rest_reg, rest_next;
    logic [gac_pkg::ATT_W-1:0]       att_reg, att_next;
    logic                            failed_reg, failed_next;

    logic [gac_pkg::KEY_W-1:0]       key_n;
    logic                            pressed;
    logic [gac_pkg::MV_W-1:0]        low_mv;
    logic [gac_pkg::ATT_W:0]         att_inc;
    logic                            above_low, below_low;
    logic                            do_halt, do_fail;

    assign up_ready = !out_valid_reg || dn_ready;
    assign step     = up_valid && up_ready;

    assign key_n     = (up_key > gac_pkg::KEY_NONE) ? gac_pkg::KEY_NONE : up_key;
    assign pressed   = (key_n != gac_pkg::KEY_NONE);
    assign idle_inc  = idle_reg + 7'd1;
    assign low_mv    = {1'b0, cfg.min_threshold_mv} + (thr_reg ? gac_pkg::HYST_MV : 15'd0);
    assign above_low = (up_mv > low_mv) && !up_gen;
    assign below_low = (up_mv < low_mv) && !up_gen;
    assign att_inc   = {1'b0, att_reg} + 3'd1;

    always_comb
    begin
        auto_next    = auto_reg;
        disp_next    = disp_reg;
        idle_next    = idle_reg;
        prev_next    = prev_reg;
        coil_next    = coil_reg;
        starter_next = starter_reg;
        thr_next     = thr_reg;
        crank_next   = crank_reg;
        rest_next    = rest_reg;
        att_next     = att_reg;
        failed_next  = failed_reg;
        do_halt      = 1'b0;
        do_fail      = 1'b0;

        // screen idle timer
        if ((key_n == gac_pkg::KEY_NONE) && (idle_reg < cfg.idle_limit) && disp_reg)
        begin
            if (idle_inc >= cfg.idle_limit)
            begin
                disp_next = 1'b0;
                idle_next = '0;
            end
            else
            begin
                disp_next = 1'b1;
                idle_next = idle_inc;
            end
        end
        else if (key_n == gac_pkg::KEY_SELECT)
        begin
            disp_next = 1'b1;
        end
        if (pressed)
        begin
            idle_next = '0;
        end

        if (!failed_reg)
        begin
            prev_next = pressed;
            if (!(prev_reg && pressed))
            begin
                if (((key_n == gac_pkg::KEY_UP) || (key_n == gac_pkg::KEY_DOWN)) && disp_next)
                begin
                    auto_next = !auto_reg;
                end
                do_halt = above_low;

                if (!auto_next)
                begin
                    att_next = '0;
                end
                else if (below_low)
                begin
                    thr_next  = 1'b1;
                    coil_next = 1'b1;
                    if ({1'b0, att_reg} >= MAX_ATT)
                    begin
                        do_fail = 1'b1;
                    end
                    else if (crank_reg < cfg.crank_ticks)
                    begin
                        starter_next = 1'b1;
                        crank_next   = crank_reg + 5'd1;
                    end
                    else if (rest_reg < cfg.rest_ticks)
                    begin
                        starter_next = 1'b0;
                        rest_next    = rest_reg + 10'd1;
                    end
                    else if (att_inc >= MAX_ATT)
                    begin
                        do_fail = 1'b1;
                    end
                    else if (cfg.crank_ticks != '0)
                    begin
                        starter_next = 1'b1;
                        att_next     = att_inc[gac_pkg::ATT_W-1:0];
                        crank_next   = 5'd1;
                        rest_next    = '0;
                    end
                    else if (cfg.rest_ticks != '0)
                    begin
                        starter_next = 1'b0;
                        att_next     = att_inc[gac_pkg::ATT_W-1:0];
                        crank_next   = '0;
                        rest_next    = 10'd1;
                    end
                    else
                    begin
                        // zero crank and rest: remaining attempts all pass this tick
                        do_fail = 1'b1;
                    end
                end
                else
                begin
                    priority if ((up_mv >= {1'b0, cfg.max_threshold_mv}) && up_gen)
                    begin
                        do_halt = 1'b1;
                    end
                    else if (above_low)
                    begin
                        do_halt  = 1'b1;
                        thr_next = 1'b0;
                    end
                    else if (up_mv > gac_pkg::FAILSAFE_MV)
                    begin
                        do_halt = 1'b1;
                    end
                    else
                    begin
                        do_halt = 1'b0;
                    end
                    if (up_gen)
                    begin
                        starter_next = 1'b0;
                        att_next     = '0;
                    end
                end

                if (do_halt || do_fail)
                begin
                    coil_next    = 1'b0;
                    starter_next = 1'b0;
                    crank_next   = '0;
                    rest_next    = '0;
                    att_next     = '0;
                end
                if (do_fail)
                begin
                    failed_next = 1'b1;
                end
            end
        end

        status_next.coil_on       = coil_next;
        status_next.starter_on    = starter_next;
        status_next.start_failed  = failed_next;
        status_next.automation_on = auto_next;
        status_next.screen_on     = disp_next;
        status_next.battery_mv    = up_mv;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            auto_reg      <= 1'b0;
            disp_reg      <= 1'b1;
            idle_reg      <= '0;
            prev_reg      <= 1'b0;
            coil_reg      <= 1'b0;
            starter_reg   <= 1'b0;
            thr_reg       <= 1'b0;
            crank_reg     <= '0;
            rest_reg      <= '0;
            att_reg       <= '0;
            failed_reg    <= 1'b0;
        end
        else
        begin
            if (up_ready)
            begin
                out_valid_reg <= up_valid;
            end
            if (step)
            begin
                auto_reg    <= auto_next;
                disp_reg    <= disp_next;
                idle_reg    <= idle_next;
                prev_reg    <= prev_next;
                coil_reg    <= coil_next;
                starter_reg <= starter_next;
                thr_reg     <= thr_next;
                crank_reg   <= crank_next;
                rest_reg    <= rest_next;
                att_reg     <= att_next;
                failed_reg  <= failed_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            status_reg <= status_next;
        end
    end

    assign dn_valid  = out_valid_reg;
    assign dn_status = status_reg;

endmodule
`default_nettype wire

>>> src/generator_autostart_controller_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// generator_autostart_controller_top - automatic generator start controller
// One input word per control tick: battery sample, running sense and key.
// One result word per tick: coil, starter, failure lamp, automation, screen
// and battery millivolts.
//
// Channels: input, result and configuration, each with valid/ready. The
// configuration port is always ready; write it only while the block is idle.
// Path: a word loaded into the input register passes through the product
// and millivolt registers to the result register.
// Throughput: one word per cycle while out_ready stays high; the per-tick state
// updates in the same cycle that the result register loads.
// Reset: configuration returns to its defaults, automation off, screen on,
// counters clear, failure latch clears, pipeline empties.
// Receiver stall: the result register holds; words already in the scaling
// stages move up behind it and the input keeps accepting until all stages
// are full, then ready drops until the result word is taken.
// ----------------------------------------------------------------------------
module generator_autostart_controller_top
#(
    parameter int MAX_ATTEMPTS = gac_pkg::MAX_ATTEMPTS_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [gac_pkg::ADC_W-1:0]    battery_adc,
    input  wire logic                         gen_running,
    input  wire logic [gac_pkg::KEY_W-1:0]    key,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              coil_on,
    output logic                              starter_on,
    output logic                              start_failed,
    output logic                              automation_on,
    output logic                              screen_on,
    output logic [gac_pkg::MV_W-1:0]          battery_mv,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [gac_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [gac_pkg::DATA_W-1:0]   cfg_data
);

    gac_pkg::cfg_t                cfg_reg;
    logic                         sc_valid, sc_ready, sc_gen;
    logic [gac_pkg::MV_W-1:0]     sc_mv;
    logic [gac_pkg::KEY_W-1:0]    sc_key;
    gac_pkg::status_t             status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_threshold_mv <= gac_pkg::MIN_THR_RST;
            cfg_reg.max_threshold_mv <= gac_pkg::MAX_THR_RST;
            cfg_reg.rest_ticks       <= gac_pkg::REST_RST;
            cfg_reg.crank_ticks      <= gac_pkg::CRANK_RST;
            cfg_reg.full_scale_mv    <= gac_pkg::FULLSCALE_RST;
            cfg_reg.idle_limit       <= gac_pkg::IDLE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                gac_pkg::REG_MIN_THR:
                begin
                    cfg_reg.min_threshold_mv <= cfg_data[gac_pkg::THR_W-1:0];
                end
                gac_pkg::REG_MAX_THR:
                begin
                    cfg_reg.max_threshold_mv <= cfg_data[gac_pkg::THR_W-1:0];
                end
                gac_pkg::REG_REST:
                begin
                    cfg_reg.rest_ticks <= cfg_data[gac_pkg::REST_W-1:0];
                end
                gac_pkg::REG_CRANK:
                begin
                    cfg_reg.crank_ticks <= cfg_data[gac_pkg::CRANK_W-1:0];
                end
                gac_pkg::REG_FULLSCALE:
                begin
                    cfg_reg.full_scale_mv <= cfg_data[gac_pkg::MV_W-1:0];
                end
                gac_pkg::REG_IDLE:
                begin
                    cfg_reg.idle_limit <= cfg_data[gac_pkg::IDLE_W-1:0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    gac_scale u_scale
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .up_valid      (in_valid),
        .up_ready      (in_ready),
        .up_adc        (battery_adc),
        .up_gen        (gen_running),
        .up_key        (key),
        .full_scale_mv (cfg_reg.full_scale_mv),
        .dn_valid      (sc_valid),
        .dn_ready      (sc_ready),
        .dn_mv         (sc_mv),
        .dn_gen        (sc_gen),
        .dn_key        (sc_key)
    );

    gac_ctrl
    #(
        .MAX_ATTEMPTS (MAX_ATTEMPTS)
    )
    u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .up_valid  (sc_valid),
        .up_ready  (sc_ready),
        .up_mv     (sc_mv),
        .up_gen    (sc_gen),
        .up_key    (sc_key),
        .dn_valid  (out_valid),
        .dn_ready  (out_ready),
        .dn_status (status)
    );

    assign coil_on       = status.coil_on;
    assign starter_on    = status.starter_on;
    assign start_failed  = status.start_failed;
    assign automation_on = status.automation_on;
    assign screen_on     = status.screen_on;
    assign battery_mv    = status.battery_mv;

endmodule
`default_nettype wire
